FILE: src/assert_macros.svh
// Assertion helpers for the shifted pixel difference block.
// Each use states the clock and the synchronous reset that disables it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants shared by the shifted pixel difference modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_OFFSET_DEF = 5;

  localparam int OFS_W      = 4;   // offset register width
  localparam int SIZE_W     = 11;  // frame size register width
  localparam int COORD_W    = 10;  // result coordinate width
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic signed [OFS_W-1:0] OFFSET_X_RST = 4'sd1;
  localparam logic signed [OFS_W-1:0] OFFSET_Y_RST = 4'sd0;
  localparam logic [SIZE_W-1:0]       WIDTH_RST    = 11'd640;
  localparam logic [SIZE_W-1:0]       HEIGHT_RST   = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X     = 2'd0,
    CFG_OFFSET_Y     = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_blue;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_red;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] target_row;
    logic [COORD_W-1:0] target_col;
    logic [CHAN_W-1:0]  diff_blue;
    logic [CHAN_W-1:0]  diff_green;
    logic [CHAN_W-1:0]  diff_red;
  } result_t;

  // Effective settings after clamping.
  typedef struct packed {
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic [OFS_W-1:0]        cs;     // column stride
    logic [OFS_W-1:0]        rs;     // row stride
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
    logic                    later;  // partner arrives after target
  } spd_cfg_t;

  // Per-pixel decision from the position tracker.
  typedef struct packed {
    logic               hit;
    logic               later;
    logic               fwd;   // partner is the pixel being written
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } spd_tap_t;

endpackage

`default_nettype wire

FILE: src/spd_cfg.sv
// ----------------------------------------------------------------------------
// spd_cfg
// Configuration registers with clamping of offsets and frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_cfg #(
  parameter int MAX_WIDTH  = spd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = spd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_OFFSET = spd_pkg::MAX_OFFSET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output spd_pkg::spd_cfg_t                    cfg
);
  import spd_pkg::*;

  logic signed [OFS_W-1:0] offset_x, offset_y;
  logic [SIZE_W-1:0]       frame_width, frame_height;
  logic signed [OFS_W-1:0] ox, oy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x     <= OFFSET_X_RST;
      offset_y     <= OFFSET_Y_RST;
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_X:     offset_x     <= cfg_data[OFS_W-1:0];
        CFG_OFFSET_Y:     offset_y     <= cfg_data[OFS_W-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ox = offset_x;
    if (int'(offset_x) > MAX_OFFSET)  ox = OFS_W'(MAX_OFFSET);
    if (int'(offset_x) < -MAX_OFFSET) ox = OFS_W'(-MAX_OFFSET);
    oy = offset_y;
    if (int'(offset_y) > MAX_OFFSET)  oy = OFS_W'(MAX_OFFSET);
    if (int'(offset_y) < -MAX_OFFSET) oy = OFS_W'(-MAX_OFFSET);

    cfg.ox = ox;
    cfg.oy = oy;
    cfg.cs = (ox < 0) ? OFS_W'(-ox) : ((ox == 0) ? OFS_W'(1) : OFS_W'(ox));
    cfg.rs = (oy < 0) ? OFS_W'(-oy) : ((oy == 0) ? OFS_W'(1) : OFS_W'(oy));
    cfg.later = (oy > 0) || ((oy == 0) && (ox > 0));

    cfg.w = frame_width;
    if (frame_width == '0)                cfg.w = SIZE_W'(1);
    else if (int'(frame_width) > MAX_WIDTH) cfg.w = SIZE_W'(MAX_WIDTH);
    cfg.h = frame_height;
    if (frame_height == '0)                 cfg.h = SIZE_W'(1);
    else if (int'(frame_height) > MAX_HEIGHT) cfg.h = SIZE_W'(MAX_HEIGHT);
  end

endmodule

`default_nettype wire

FILE: src/spd_store.sv
// ----------------------------------------------------------------------------
// spd_store
// Row store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_store #(
  parameter int DEPTH = 6 * spd_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   waddr,
  input  spd_pkg::pixel_t      wdata,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   raddr,
  output spd_pkg::pixel_t      rdata
);
  import spd_pkg::*;

  pixel_t mem [DEPTH];

  // Read returns the old contents on a same-address collision.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/spd_ctrl.sv
// ----------------------------------------------------------------------------
// spd_ctrl
// Raster position tracking, target grid test and store addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_ctrl #(
  parameter int MAX_WIDTH  = spd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = spd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_OFFSET = spd_pkg::MAX_OFFSET_DEF,
  parameter int AW         = $clog2((MAX_OFFSET + 1) * MAX_WIDTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  spd_pkg::spd_cfg_t  cfg,
  output spd_pkg::spd_tap_t  tap,
  output logic [AW-1:0]      waddr,
  output logic [AW-1:0]      raddr
);
  import spd_pkg::*;

  localparam int STORE_ROWS = MAX_OFFSET + 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SW  = $clog2(STORE_ROWS);
  localparam int IW  = $clog2(MAX_OFFSET + 1);
  localparam int XW  = ((CW > SIZE_W) ? CW : SIZE_W) + 2;
  localparam int YW  = ((RW > SIZE_W) ? RW : SIZE_W) + 2;
  localparam int BW  = ((SW > OFS_W) ? SW : OFS_W) + 1;

  logic [CW-1:0] cc;
  logic [RW-1:0] cr;
  logic [SW-1:0] slot;
  logic          col_wrap, row_wrap;

  logic [MAX_OFFSET:1] col_zero, row_zero;

  logic signed [XW-1:0] tc, rcol_full;
  logic signed [YW-1:0] tr;
  logic [CW-1:0]        rcol;
  logic [BW-1:0]        back, rslot_full;
  logic [SW-1:0]        rslot;
  logic                 row_ok, col_ok;

  assign col_wrap = (XW'(cc) + XW'(1)) >= XW'(cfg.w);
  assign row_wrap = (YW'(cr) + YW'(1)) >= YW'(cfg.h);

  always_ff @(posedge clk) begin
    if (rst) begin
      cc   <= '0;
      cr   <= '0;
      slot <= '0;
    end else if (advance) begin
      if (col_wrap) begin
        cc <= '0;
        if (row_wrap) begin
          cr   <= '0;
          slot <= '0;
        end else begin
          cr   <= cr + 1'b1;
          slot <= (slot == SW'(STORE_ROWS - 1)) ? '0 : slot + 1'b1;
        end
      end else begin
        cc <= cc + 1'b1;
      end
    end
  end

  // Position modulo every possible stride, kept per stride so that an
  // offset change never needs a division.
  for (genvar s = 1; s <= MAX_OFFSET; s++) begin : g_phase
    logic [IW-1:0] cph, rph;

    always_ff @(posedge clk) begin
      if (rst) begin
        cph <= '0;
        rph <= '0;
      end else if (advance) begin
        if (col_wrap) begin
          cph <= '0;
          if (row_wrap || (rph == IW'(s - 1))) rph <= '0;
          else rph <= rph + 1'b1;
        end else if (cph == IW'(s - 1)) begin
          cph <= '0;
        end else begin
          cph <= cph + 1'b1;
        end
      end
    end

    assign col_zero[s] = (cph == '0);
    assign row_zero[s] = (rph == '0);
  end

  always_comb begin
    // Target: the current pixel, or the one an offset back.
    tr = $signed(YW'(cr));
    tc = $signed(XW'(cc));
    if (cfg.later) begin
      tr = tr - YW'(cfg.oy);
      tc = tc - XW'(cfg.ox);
    end

    // Offsets are multiples of their stride, so target phase == current phase.
    row_ok = (tr >= $signed(YW'(cfg.rs)))
          && ((tr + $signed(YW'(cfg.rs))) < $signed(YW'(cfg.h)))
          && row_zero[cfg.rs[IW-1:0]];
    col_ok = (tc >= $signed(XW'(cfg.cs)))
          && ((tc + $signed(XW'(cfg.cs))) < $signed(XW'(cfg.w)))
          && col_zero[cfg.cs[IW-1:0]];

    // Stored pixel of the pair sits |oy| rows back in the ring.
    back = (cfg.oy == 0) ? '0 : BW'(cfg.rs);
    if (BW'(slot) >= back) rslot_full = BW'(slot) - back;
    else rslot_full = BW'(slot) + BW'(STORE_ROWS) - back;
    rslot = rslot_full[SW-1:0];

    rcol_full = cfg.later ? ($signed(XW'(cc)) - XW'(cfg.ox))
                          : ($signed(XW'(cc)) + XW'(cfg.ox));
    rcol = rcol_full[CW-1:0];

    waddr = AW'(slot) * AW'(MAX_WIDTH) + AW'(cc);
    raddr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(rcol);

    tap.hit   = row_ok && col_ok;
    tap.later = cfg.later;
    tap.fwd   = (rslot == slot) && (rcol == cc);
    tap.row   = COORD_W'(tr);
    tap.col   = COORD_W'(tc);
  end

endmodule

`default_nettype wire

FILE: src/shifted_pixel_difference_core.sv
// ----------------------------------------------------------------------------
// shifted_pixel_difference_core
// Directional difference of a raster pixel stream against a shifted partner.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel:  raster-order BGR pixels, one transfer per valid & !stall.
//   result channel: one transfer per target on the stride grid, carrying the
//                   target row/col and max(target - partner, 0) per channel.
//   cfg channel:    index/data writes, always ready; write offsets and frame
//                   size only while no pixel is in flight.
//   Throughput: one pixel per cycle while pixel_stall is low, with the row
//   store doing one write and one read for each accepted pixel.
//   Result path: the pixel that completes the pair passes the store read
//   stage, then the output register, which raises result_valid.
//   Reset (rst, synchronous): row/column counters to zero, offsets to (1, 0),
//   size 640x480, pipeline empty. The row store is not cleared; entries that
//   feed a result are only read after the frame has written them.
//   Stall: a held result keeps its value; one more hit can wait in the store
//   read stage, and pixels that produce no result keep flowing. Once both are
//   full, pixel_stall rises in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module shifted_pixel_difference_core #(
  parameter int MAX_WIDTH  = spd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = spd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_OFFSET = spd_pkg::MAX_OFFSET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pixel_valid,
  output logic                                 pixel_stall,
  input  spd_pkg::pixel_t                      pixel,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output spd_pkg::result_t                     result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spd_pkg::*;

  localparam int DEPTH = (MAX_OFFSET + 1) * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [CHAN_W-1:0] sat_sub(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  spd_cfg_t      cfg;
  spd_tap_t      tap;
  logic [AW-1:0] waddr, raddr;
  pixel_t        rdata;

  logic     accept;
  logic     out_take;
  logic     s1_valid;     // a hit waiting on store read data
  spd_tap_t s1_tap;
  pixel_t   s1_pixel;
  pixel_t   stored, tp, pp;

  spd_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_OFFSET (MAX_OFFSET)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_OFFSET (MAX_OFFSET),
    .AW         (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .cfg     (cfg),
    .tap     (tap),
    .waddr   (waddr),
    .raddr   (raddr)
  );

  spd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .wr_en (accept),
    .waddr (waddr),
    .wdata (pixel),
    .rd_en (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register frees when empty or when its result transfers.
  assign out_take    = !result_valid || !result_stall;
  // Read stage blocks only when it holds a hit the output cannot take.
  assign pixel_stall = s1_valid && !out_take;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || out_take) begin
      s1_valid <= accept && tap.hit;
    end
  end

  // Store read data is held with it: no new read issues while s1 is stuck.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_tap   <= tap;
    end
  end

  always_comb begin
    // Zero offsets read the entry written in the same cycle.
    stored = s1_tap.fwd ? s1_pixel : rdata;
    tp     = s1_tap.later ? stored : s1_pixel;
    pp     = s1_tap.later ? s1_pixel : stored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_take) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      result.target_row <= s1_tap.row;
      result.target_col <= s1_tap.col;
      result.diff_blue  <= sat_sub(tp.pixel_blue,  pp.pixel_blue);
      result.diff_green <= sat_sub(tp.pixel_green, pp.pixel_green);
      result.diff_red   <= sat_sub(tp.pixel_red,   pp.pixel_red);
    end
  end

  // An empty output register never holds back the pixel stream.
  `SPD_ASSERT_NOW(a_no_stall_when_empty, clk, rst, !result_valid, !pixel_stall, "stall with empty output")
  // A pending hit reaches the output once the output can take it.
  `SPD_ASSERT_NEXT(a_hit_moves_out, clk, rst, s1_valid && out_take, result_valid, "hit lost in read stage")
  // Same-entry forwarding only occurs with both offsets at zero.
  `SPD_ASSERT_NOW(a_fwd_zero_offset, clk, rst, accept && tap.fwd, (cfg.ox == 0) && (cfg.oy == 0), "forward with nonzero offset")

endmodule

`default_nettype wire

FILE: tb/shifted_pixel_difference_checker.sv
// ----------------------------------------------------------------------------
// shifted_pixel_difference_checker
// Watches the pixel, result and config channels of the core. It keeps its own
// row store, position counters and register copies, predicts the difference
// for each pixel that completes a pair, and compares result transfers in order.
// ----------------------------------------------------------------------------
module shifted_pixel_difference_checker
  import spd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pixel_valid,
  input  wire logic                  pixel_stall,
  input  pixel_t                     pixel,
  input  wire logic                  result_valid,
  input  wire logic                  result_stall,
  input  result_t                    result,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         outstanding,
  output int                         failures
);

  localparam int STORE_ROWS = MAX_OFFSET_DEF + 1;
  localparam int REPORT_CAP = 100;  // keep a broken run's log readable

  pixel_t           row_store [STORE_ROWS*MAX_WIDTH_DEF];
  int               cur_row;
  int               cur_col;
  logic [OFS_W-1:0]  ofs_x_reg;
  logic [OFS_W-1:0]  ofs_y_reg;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  result_t          pending_diffs [$];
  int               fail_count = 0;
  int               queued = 0;

  assign outstanding = queued;
  assign failures    = fail_count;

  function automatic int eff_offset(logic [OFS_W-1:0] raw);
    int v;
    v = $signed(raw);
    if (v > MAX_OFFSET_DEF) v = MAX_OFFSET_DEF;
    if (v < -MAX_OFFSET_DEF) v = -MAX_OFFSET_DEF;
    return v;
  endfunction

  function automatic int eff_size(logic [SIZE_W-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic bit on_grid(int p, int stride, int size);
    return p >= stride && p + stride < size && (p % stride) == 0;
  endfunction

  function automatic logic [CHAN_W-1:0] floor_sub(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Store the pixel, decide whether it completes a target/partner pair and
  // advance the raster position.
  function automatic void shift_difference(input pixel_t px, output bit hit,
                                           output result_t diff);
    int     ox, oy, w, h, cs, rs, tr, tc;
    bit     later;
    pixel_t tgt, ptn;
    ox = eff_offset(ofs_x_reg);
    oy = eff_offset(ofs_y_reg);
    w  = eff_size(width_reg, MAX_WIDTH_DEF);
    h  = eff_size(height_reg, MAX_HEIGHT_DEF);
    cs = (ox < 0) ? -ox : ((ox == 0) ? 1 : ox);
    rs = (oy < 0) ? -oy : ((oy == 0) ? 1 : oy);
    later = (oy > 0) || (oy == 0 && ox > 0);
    row_store[(cur_row % STORE_ROWS)*MAX_WIDTH_DEF + cur_col] = px;
    tr = later ? cur_row - oy : cur_row;
    tc = later ? cur_col - ox : cur_col;
    hit  = on_grid(tr, rs, h) && on_grid(tc, cs, w);
    diff = '0;
    if (hit) begin
      if (later) begin
        ptn = px;
        tgt = row_store[(tr % STORE_ROWS)*MAX_WIDTH_DEF + tc];
      end else begin
        tgt = px;
        ptn = row_store[((tr + oy) % STORE_ROWS)*MAX_WIDTH_DEF + tc + ox];
      end
      diff.target_row = COORD_W'(tr);
      diff.target_col = COORD_W'(tc);
      diff.diff_blue  = floor_sub(tgt.pixel_blue, ptn.pixel_blue);
      diff.diff_green = floor_sub(tgt.pixel_green, ptn.pixel_green);
      diff.diff_red   = floor_sub(tgt.pixel_red, ptn.pixel_red);
    end
    if (cur_col + 1 >= w) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      if (fail_count < REPORT_CAP)
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bit      hit;
    result_t want;
    if (rst) begin
      cur_row    = 0;
      cur_col    = 0;
      ofs_x_reg  = OFFSET_X_RST;
      ofs_y_reg  = OFFSET_Y_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      pending_diffs.delete();
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_reg_t'(cfg_index))
          CFG_OFFSET_X:     ofs_x_reg  = cfg_data[OFS_W-1:0];
          CFG_OFFSET_Y:     ofs_y_reg  = cfg_data[OFS_W-1:0];
          CFG_FRAME_WIDTH:  width_reg  = cfg_data;
          CFG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (pixel_valid === 1'b1 && pixel_stall === 1'b0) begin
        shift_difference(pixel, hit, want);
        if (hit) pending_diffs.push_back(want);
      end
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        if (pending_diffs.size() == 0) begin
          if (fail_count < REPORT_CAP)
            $error("result transfer with nothing predicted: row %0d col %0d",
                   result.target_row, result.target_col);
          fail_count++;
        end else begin
          want = pending_diffs.pop_front();
          check_field("target_row", want.target_row, result.target_row);
          check_field("target_col", want.target_col, result.target_col);
          check_field("diff_blue", want.diff_blue, result.diff_blue);
          check_field("diff_green", want.diff_green, result.diff_green);
          check_field("diff_red", want.diff_red, result.diff_red);
        end
      end
    end
    queued = pending_diffs.size();
  end

endmodule

FILE: tb/shifted_pixel_difference_core_tb.sv
// ----------------------------------------------------------------------------
// shifted_pixel_difference_core_tb
// Streams raster frames through the core under a series of offset and frame
// size settings, with bursty input and a stalling result side. A checker
// beside the core predicts every result; this module makes the stimulus and
// prints the verdict.
// ----------------------------------------------------------------------------
module shifted_pixel_difference_core_tb;
  import spd_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int SETTLE      = 4;    // margin for pixels that produce no result
  localparam int DRAIN       = 8;
  localparam int HOLDOFF     = 400;  // long result-side hold, fills the core
  localparam int RANDOM_ITEMS = 950;

  typedef enum int {FLOW, COIN, CHOKE, ALTERNATE} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  pixel_t                pixel = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int pending_count;
  int mismatch_total;
  int cycle_count = 0;
  int burst_left = 0;
  int frame_len = 0;
  bit hold_armed = 1'b0;
  bit held_off = 1'b0;

  shifted_pixel_difference_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  shifted_pixel_difference_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (pending_count),
    .failures     (mismatch_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All drive at the falling edge; handshakes are sampled at
  // the rising edge. Each task is entered and left on a falling edge.
  // --------------------------------------------------------------------------

  // Channel value with the extremes well represented.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.pixel_blue  = rand_chan();
    p.pixel_green = rand_chan();
    p.pixel_red   = rand_chan();
    return p;
  endfunction

  // Offset of magnitude at most one, so the stride stays 1 on that axis.
  function automatic logic [OFS_W-1:0] unit_offset();
    case ($urandom_range(0, 2))
      0:       return 4'h0;
      1:       return 4'h1;
      default: return 4'hF;
    endcase
  endfunction

  function automatic int clamp_dim(logic [SIZE_W-1:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // One pixel transfer. Bursts of random length with random gaps; a quarter
  // of the bursts start with no gap, so back-to-back stretches occur.
  // Valid stays high across a stall and the payload holds.
  task automatic push_pixel(input pixel_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (pixel_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    repeat (n) push_pixel(rand_pixel());
  endtask

  // Caller lowers cfg_valid after its last write.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only with the core idle: every predicted result has
  // come out, plus a SETTLE wait for pixels that produce none.
  // Unused upper data bits of the offset writes are randomized.
  task automatic reconfigure(input logic [OFS_W-1:0] ox, input logic [OFS_W-1:0] oy,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    logic [CFG_DATA_W-OFS_W-1:0] pad_x, pad_y;
    pad_x = $urandom;
    pad_y = $urandom;
    pixel_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    write_reg(CFG_OFFSET_X, {pad_x, ox});
    write_reg(CFG_OFFSET_Y, {pad_y, oy});
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
    frame_len = clamp_dim(w, MAX_WIDTH_DEF) * clamp_dim(h, MAX_HEIGHT_DEF);
  endtask

  // --------------------------------------------------------------------------
  // Result side: stalls in segments of random length and character, and once
  // holds off for a long stretch while the wide frame is streaming, so the
  // core backs up and stalls its pixel input.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int          run;
    stall_mode_t mode;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_armed && !held_off) begin
        result_stall <= 1'b1;
        repeat (HOLDOFF) @(negedge clk);
        held_off = 1'b1;
      end else begin
        run  = $urandom_range(4, 40);
        mode = stall_mode_t'($urandom_range(0, 3));
        repeat (run) begin
          case (mode)
            FLOW:      result_stall <= 1'b0;
            COIN:      result_stall <= ($urandom_range(0, 1) == 0);
            CHOKE:     result_stall <= ($urandom_range(0, 4) != 0);
            ALTERNATE: result_stall <= ~result_stall;
            default:   result_stall <= 1'b0;
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. Every phase after the mid-frame one starts at the frame origin
  // and sends whole frames, so no store entry is read before it is written.
  // --------------------------------------------------------------------------
  initial begin : pixel_side
    pixel_t           px;
    logic [OFS_W-1:0]  ox, oy;
    logic [SIZE_W-1:0] w, h;
    int               frames;
    int               random_sent;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings (offset +1,0 on 640x480): finish row 0 and start row 1,
    // which gives the first few targets.
    send_random(645);

    // Mid-frame change to 4 wide and height 0 (clamps to 1): both counters
    // now lie past the new size and wrap together on the next pixel. Offsets
    // stay +1,0 so nothing outside the current row is read.
    reconfigure(4'h1, 4'h0, 11'd4, 11'd0);
    send_random(5);

    // Saturation both ways on a 3x3 frame: blue and green flip between 00 and FF
    // from pixel to pixel, and the phase flips between the two frames.
    reconfigure(4'h1, 4'h0, 11'd3, 11'd3);
    for (int f = 0; f < 2; f++) begin
      for (int k = 0; k < 9; k++) begin
        px.pixel_blue  = (k[0] ^ f[0]) ? 8'hFF : 8'h00;
        px.pixel_green = (k[0] ^ f[0]) ? 8'h00 : 8'hFF;
        px.pixel_red   = (f == 0) ? 8'h80 : ((k < 5) ? 8'hFF : 8'h01);
        push_pixel(px);
      end
    end

    // Zero offsets: partner is the target itself, all-zero difference.
    reconfigure(4'h0, 4'h0, 11'd3, 11'd3);
    send_random(9);

    // Offsets past the limit saturate to +-5; one target at (5,5) each way.
    reconfigure(4'h7, 4'h8, 11'd11, 11'd11);
    send_random(121);
    reconfigure(4'h8, 4'h7, 11'd11, 11'd11);
    send_random(121);

    // Random offsets over the full register range, mostly small frames,
    // with an occasional frame too small to hold any target.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      ox = $urandom;
      oy = $urandom;
      w  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
      h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      reconfigure(ox, oy, w, h);
      frames = (frame_len > 150) ? 1 : $urandom_range(1, 3);
      send_random(frames * frame_len);
      random_sent += frames * frame_len;
    end

    // Widest frame (2047 clamps to 1024), three rows: targets across the full
    // column range. The long result hold starts once row 1 is under way.
    reconfigure(unit_offset(), unit_offset(), 11'h7FF, 11'd3);
    for (int i = 0; i < 3 * MAX_WIDTH_DEF; i++) begin
      if (i == 1100) hold_armed = 1'b1;
      push_pixel(rand_pixel());
    end

    // Tallest frame, three columns: targets across the full row range.
    reconfigure(unit_offset(), unit_offset(), 11'd3, 11'd1024);
    send_random(3 * MAX_HEIGHT_DEF);

    // Drain: everything predicted must arrive, then allow for stragglers.
    pixel_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (mismatch_total == 0 && pending_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/spd_pkg.sv
src/spd_cfg.sv
src/spd_store.sv
src/spd_ctrl.sv
src/shifted_pixel_difference_core.sv
tb/shifted_pixel_difference_checker.sv
tb/shifted_pixel_difference_core_tb.sv
